[sv/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the point in tetrahedron test.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PIT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("pit assertion failed");
`define PIT_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("pit forbidden condition seen");
`else
`define PIT_ASSERT(lbl, prop)
`define PIT_ASSERT_NEVER(lbl, expr)
`endif
`endif

[sv/pit_pkg.sv]
// Package with constants, types and schedule tables of the point in tetrahedron test.
`timescale 1ns / 1ps
`default_nettype none
package pit_pkg;

    localparam int COORD_BITS_DEF  = 24;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    // Difference vectors carried from front to back.
    localparam logic [2:0] V_E1 = 3'd0;
    localparam logic [2:0] V_E2 = 3'd1;
    localparam logic [2:0] V_E3 = 3'd2;
    localparam logic [2:0] V_Q  = 3'd3;
    localparam logic [2:0] V_F2 = 3'd4;
    localparam logic [2:0] V_F3 = 3'd5;
    localparam logic [2:0] V_G  = 3'd6;
    localparam int N_VEC = 7;

    localparam int N_CROSS     = 4;
    localparam int N_DOT       = 5;
    localparam int CROSS_STEPS = 2 * N_CROSS;
    localparam int MUL_STEPS   = 2 * (N_CROSS + N_DOT);
    localparam int STEP_W      = $clog2(MUL_STEPS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_back_state;

    function automatic logic [2:0] cross_u(input logic [1:0] k);
        logic [2:0] r;
        unique case (k)
            2'd0:    r = V_E2;
            2'd1:    r = V_E3;
            2'd2:    r = V_E1;
            default: r = V_F2;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] cross_v(input logic [1:0] k);
        logic [2:0] r;
        unique case (k)
            2'd0:    r = V_E3;
            2'd1:    r = V_E1;
            2'd2:    r = V_E2;
            default: r = V_F3;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] dot_vec(input logic [2:0] k);
        logic [2:0] r;
        unique case (k)
            3'd0:    r = V_E1;
            3'd1:    r = V_Q;
            3'd2:    r = V_Q;
            3'd3:    r = V_Q;
            default: r = V_G;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] dot_cross(input logic [2:0] k);
        logic [1:0] r;
        unique case (k)
            3'd0:    r = 2'd0;
            3'd1:    r = 2'd0;
            3'd2:    r = 2'd1;
            3'd3:    r = 2'd2;
            default: r = 2'd3;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] lane_next(input int l);
        return (l == 2) ? 2'd0 : 2'(l + 1);
    endfunction

    function automatic logic [1:0] lane_prev(input int l);
        return (l == 0) ? 2'd2 : 2'(l - 1);
    endfunction

endpackage
`default_nettype wire

[sv/point_in_tetrahedron_test.sv]
// Point in tetrahedron test: top level joining front, request queue and back.
//
// Requests enter as from a queue: push with full. A load request writes one
// corner of one of two vertex sets at once and gives no result. A test request
// gives a query point and a set; its edge vectors are formed on acceptance and
// wait in a two-entry queue. Results leave as from a queue: the oldest result
// is on o_inside_res while empty is low and is taken with pop.
// The back runs each test through three shared multiplier lanes: eight steps
// for four cross products and ten for five split dot products; it takes the
// next test from the queue only once it has passed on the result of the
// last. Loads are taken one per cycle while the queue is not full.
// When the receiver stalls, one result waits in the output register, the back
// holds the next finished test, and the queue fills until full rises.
// Reset clears both vertex sets to zero and empties queue and output.
`timescale 1ns / 1ps
`default_nettype none
module point_in_tetrahedron_test #(
    parameter int COORD_BITS  = pit_pkg::COORD_BITS_DEF,
    parameter int QUEUE_DEPTH = pit_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         i_opcode,
    input  logic                         i_coord_set,
    input  logic [1:0]                   i_corner_slot,
    input  logic signed [COORD_BITS-1:0] i_coord_x,
    input  logic signed [COORD_BITS-1:0] i_coord_y,
    input  logic signed [COORD_BITS-1:0] i_coord_z,
    output logic                         empty,
    input  logic                         pop,
    output logic                         o_inside_res
);
    import pit_pkg::*;

    localparam int EW = N_VEC * 3 * (COORD_BITS + 1);

    logic          w_q_push, w_q_pop, w_q_valid;
    logic [EW-1:0] w_f_entry, w_b_entry;

    pit_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_full        (full),
        .i_opcode      (i_opcode),
        .i_coord_set   (i_coord_set),
        .i_corner_slot (i_corner_slot),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_coord_z     (i_coord_z),
        .o_q_push      (w_q_push),
        .o_entry       (w_f_entry)
    );

    pit_queue #(.DEPTH(QUEUE_DEPTH), .WIDTH(EW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_f_entry),
        .o_full  (full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_b_entry)
    );

    pit_back #(.COORD_BITS(COORD_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .i_entry  (w_b_entry),
        .o_pop    (w_q_pop),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_inside (o_inside_res)
    );

`include "assert_macros.svh"

    `PIT_ASSERT_NEVER(a_push_when_full, w_q_push && full)
    `PIT_ASSERT(a_pop_has_entry, w_q_pop |-> w_q_valid)
    `PIT_ASSERT(a_done_shows_result, w_q_pop |=> !empty)

endmodule
`default_nettype wire

[sv/pit_queue.sv]
// Short request queue between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
module pit_queue #(
    parameter int DEPTH = pit_pkg::QUEUE_DEPTH_DEF,
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    import pit_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_wr, w_rd;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_rd) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

[sv/pit_front.sv]
// Front part: corner store, load handling and edge vectors for test requests.
`timescale 1ns / 1ps
`default_nettype none
module pit_front #(
    parameter int COORD_BITS = pit_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic                         i_full,
    input  logic                         i_opcode,
    input  logic                         i_coord_set,
    input  logic [1:0]                   i_corner_slot,
    input  logic signed [COORD_BITS-1:0] i_coord_x,
    input  logic signed [COORD_BITS-1:0] i_coord_y,
    input  logic signed [COORD_BITS-1:0] i_coord_z,
    output logic                         o_q_push,
    output logic [pit_pkg::N_VEC*3*(COORD_BITS+1)-1:0] o_entry
);
    import pit_pkg::*;

    localparam int C = COORD_BITS;
    localparam int D = COORD_BITS + 1;

    logic [3*C-1:0]      r_corner [2][4];
    logic signed [C-1:0] w_c [4][3];
    logic signed [C-1:0] w_p [3];
    logic signed [D-1:0] w_vec [N_VEC][3];
    logic                w_accept;

    assign w_accept = i_push && !i_full;
    assign o_q_push = w_accept && (i_opcode == OP_TEST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < 2; s++) begin
                for (int k = 0; k < 4; k++) begin
                    r_corner[s][k] <= '0;
                end
            end
        end else if (w_accept && (i_opcode == OP_LOAD)) begin
            r_corner[i_coord_set][i_corner_slot] <= {i_coord_z, i_coord_y, i_coord_x};
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            for (int a = 0; a < 3; a++) begin
                w_c[k][a] = r_corner[i_coord_set][k][a*C +: C];
            end
        end
        w_p[0] = i_coord_x;
        w_p[1] = i_coord_y;
        w_p[2] = i_coord_z;
        // Differences of two coordinates need one extra bit and no more.
        for (int a = 0; a < 3; a++) begin
            w_vec[V_E1][a] = D'(w_c[0][a]) - D'(w_c[3][a]);
            w_vec[V_E2][a] = D'(w_c[1][a]) - D'(w_c[3][a]);
            w_vec[V_E3][a] = D'(w_c[2][a]) - D'(w_c[3][a]);
            w_vec[V_Q][a]  = D'(w_p[a])    - D'(w_c[3][a]);
            w_vec[V_F2][a] = D'(w_c[1][a]) - D'(w_c[0][a]);
            w_vec[V_F3][a] = D'(w_c[2][a]) - D'(w_c[0][a]);
            w_vec[V_G][a]  = D'(w_p[a])    - D'(w_c[0][a]);
        end
        for (int v = 0; v < N_VEC; v++) begin
            for (int a = 0; a < 3; a++) begin
                o_entry[(v*3+a)*D +: D] = w_vec[v][a];
            end
        end
    end

endmodule
`default_nettype wire

[sv/pit_back.sv]
// Back part: three shared multiplier lanes that work out the determinant signs.
`timescale 1ns / 1ps
`default_nettype none
module pit_back #(
    parameter int COORD_BITS = pit_pkg::COORD_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic [pit_pkg::N_VEC*3*(COORD_BITS+1)-1:0] i_entry,
    output logic o_pop,
    output logic o_empty,
    input  logic i_pop,
    output logic o_inside
);
    import pit_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int D  = C + 1;
    localparam int BW = C + 3;
    localparam int PW = D + BW;
    localparam int MW = 2 * C + 3;
    localparam int K  = C + 2;
    localparam int AW = 3 * C + 8;

    t_back_state         r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [STEP_W-1:0]   w_mt, w_pc, w_pt;
    logic                w_m_cross, w_c_cross, w_cons, w_load;
    logic [1:0]          w_m_ck, w_c_ck;
    logic [2:0]          w_m_dk, w_c_dk;
    logic signed [D-1:0]  w_opa [3];
    logic signed [BW-1:0] w_opb [3];
    logic signed [PW-1:0] w_prod [3];
    logic signed [PW-1:0] r_prod [3];
    logic signed [PW-1:0] r_pa [3];
    logic signed [PW-1:0] w_diff [3];
    logic signed [MW-1:0] r_cross [N_CROSS][3];
    logic signed [AW-1:0] r_acc, w_sum, w_tot;
    logic [N_DOT-1:0]    r_neg, r_pos;
    logic                r_res_valid, r_inside, w_inside;

    function automatic logic signed [D-1:0] comp(input logic [2:0] vi, input logic [1:0] ax);
        return i_entry[(int'(vi) * 3 + int'(ax)) * D +: D];
    endfunction

    // Step decode: the multiply runs at r_step, its product is registered in r_prod and used in the next cycle.
    assign w_mt      = r_step - STEP_W'(CROSS_STEPS);
    assign w_m_cross = (r_step < STEP_W'(CROSS_STEPS));
    assign w_m_ck    = r_step[2:1];
    assign w_m_dk    = w_mt[3:1];
    assign w_pc      = r_step - 1'b1;
    assign w_pt      = w_pc - STEP_W'(CROSS_STEPS);
    assign w_c_cross = (w_pc < STEP_W'(CROSS_STEPS));
    assign w_c_ck    = w_pc[2:1];
    assign w_c_dk    = w_pt[3:1];
    assign w_cons    = (r_state == ST_RUN) && (r_step != '0);

    always_comb begin
        logic signed [D-1:0]  vb;
        logic signed [MW-1:0] mm;
        for (int l = 0; l < 3; l++) begin
            vb = '0;
            mm = '0;
            if (w_m_cross) begin
                w_opa[l] = r_step[0] ? comp(cross_u(w_m_ck), lane_prev(l))
                                     : comp(cross_u(w_m_ck), lane_next(l));
                vb       = r_step[0] ? comp(cross_v(w_m_ck), lane_next(l))
                                     : comp(cross_v(w_m_ck), lane_prev(l));
                w_opb[l] = {{2{vb[D-1]}}, vb};
            end else begin
                // The wide minor is split: upper signed half first, then lower unsigned half.
                w_opa[l] = comp(dot_vec(w_m_dk), 2'(l));
                mm       = r_cross[dot_cross(w_m_dk)][l];
                w_opb[l] = r_step[0] ? {1'b0, mm[K-1:0]}
                                     : {{2{mm[MW-1]}}, mm[MW-1:K]};
            end
            w_prod[l] = w_opa[l] * w_opb[l];
            w_diff[l] = r_pa[l] - r_prod[l];
        end
    end

    assign w_sum = AW'(r_prod[0]) + AW'(r_prod[1]) + AW'(r_prod[2]);
    assign w_tot = r_acc + w_sum;

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            r_prod[l] <= w_prod[l];
        end
        if (w_cons) begin
            if (w_c_cross) begin
                for (int l = 0; l < 3; l++) begin
                    if (!w_pc[0]) begin
                        r_pa[l] <= r_prod[l];
                    end else begin
                        r_cross[w_c_ck][l] <= w_diff[l][MW-1:0];
                    end
                end
            end else if (!w_pc[0]) begin
                r_acc <= w_sum <<< K;
            end else begin
                r_neg[w_c_dk] <= w_tot[AW-1];
                r_pos[w_c_dk] <= !w_tot[AW-1] && (w_tot != '0);
            end
        end
    end

    // The last determinant is formed with the opposite sign, so its flags swap.
    assign w_inside = r_neg[0] ? (r_neg[1] && r_neg[2] && r_neg[3] && r_pos[4])
                               : (r_pos[1] && r_pos[2] && r_pos[3] && r_neg[4]);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_pop   = 1'b0;
        w_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_RUN;
                    n_step  = '0;
                end
            end
            ST_RUN: begin
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(MUL_STEPS)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_res_valid || i_pop) begin
                    o_pop   = 1'b1;
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (w_load) begin
                r_res_valid <= 1'b1;
            end else if (i_pop) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_inside <= w_inside;
        end
    end

    assign o_empty  = !r_res_valid;
    assign o_inside = r_inside;

endmodule
`default_nettype wire

[bench/tb.sv]
// Self-checking testbench for the point in tetrahedron test block.
`timescale 1ns / 1ps
`default_nettype none

// Holds the predicted inside flags of accepted test requests.
class inside_scoreboard;
    bit inside_q[$];
    int n_fail;
    int n_checked;
    int n_inside;

    function void note_test(bit inside_flag);
        inside_q.push_back(inside_flag);
    endfunction

    function void check_result(bit actual);
        bit want;
        if (inside_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0d", $time, actual);
            n_fail++;
            return;
        end
        want = inside_q.pop_front();
        n_checked++;
        if (want) n_inside++;
        if (want !== actual) begin
            $display("%0t: inside_res mismatch, expected %0d, actual %0d",
                     $time, want, actual);
            n_fail++;
        end
    endfunction
endclass

module tb;
    import pit_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    typedef logic signed [CB-1:0] coord_t;
    typedef logic signed [127:0] wide_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       pop = 1'b0;
    logic       i_opcode = OP_LOAD;
    logic       i_coord_set = 1'b0;
    logic [1:0] i_corner_slot = 2'd0;
    coord_t     i_coord_x = '0;
    coord_t     i_coord_y = '0;
    coord_t     i_coord_z = '0;
    logic       full;
    logic       empty;
    logic       o_inside_res;

    // Shadow copy of the two vertex sets: [set*4 + slot][axis].
    coord_t corners [8][3];
    inside_scoreboard sb;
    bit stim_done = 1'b0;
    int n_loads = 0;
    int n_tests = 0;

    point_in_tetrahedron_test dut (
        .i_clk, .i_rst_n, .push, .full, .i_opcode, .i_coord_set, .i_corner_slot,
        .i_coord_x, .i_coord_y, .i_coord_z, .empty, .pop, .o_inside_res
    );

    always #5 i_clk = ~i_clk;

    function automatic wide_t det3(wide_t ax, wide_t ay, wide_t az, wide_t bx, wide_t by,
                                   wide_t bz, wide_t cx, wide_t cy, wide_t cz);
        return ax * (by * cz - bz * cy) - ay * (bx * cz - bz * cx)
             + az * (bx * cy - by * cx);
    endfunction

    function automatic bit point_inside(bit set, coord_t px, coord_t py, coord_t pz);
        wide_t c [4][3];
        wide_t e1 [3];
        wide_t e2 [3];
        wide_t e3 [3];
        wide_t q [3];
        wide_t f2 [3];
        wide_t f3 [3];
        wide_t g [3];
        wide_t d0, d1, d2, d3, d4;
        for (int i = 0; i < 4; i++)
            for (int a = 0; a < 3; a++)
                c[i][a] = wide_t'(corners[set*4+i][a]);
        q[0] = wide_t'(px) - c[3][0];
        q[1] = wide_t'(py) - c[3][1];
        q[2] = wide_t'(pz) - c[3][2];
        for (int a = 0; a < 3; a++) begin
            e1[a] = c[0][a] - c[3][a];
            e2[a] = c[1][a] - c[3][a];
            e3[a] = c[2][a] - c[3][a];
            f2[a] = e2[a] - e1[a];
            f3[a] = e3[a] - e1[a];
            g[a]  = q[a] - e1[a];
        end
        d0 = det3(e1[0], e1[1], e1[2], e2[0], e2[1], e2[2], e3[0], e3[1], e3[2]);
        d1 = det3(q[0], q[1], q[2], e2[0], e2[1], e2[2], e3[0], e3[1], e3[2]);
        d2 = det3(e1[0], e1[1], e1[2], q[0], q[1], q[2], e3[0], e3[1], e3[2]);
        d3 = det3(e1[0], e1[1], e1[2], e2[0], e2[1], e2[2], q[0], q[1], q[2]);
        d4 = -det3(f2[0], f2[1], f2[2], f3[0], f3[1], f3[2], g[0], g[1], g[2]);
        if (d0 < 0)
            return d1 < 0 && d2 < 0 && d3 < 0 && d4 < 0;
        return d1 > 0 && d2 > 0 && d3 > 0 && d4 > 0;
    endfunction

    // Push stays high from one request into the next when there is no gap.
    task automatic send_request(bit op, bit set, logic [1:0] slot,
                                coord_t x, coord_t y, coord_t z);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_opcode <= op;
        i_coord_set <= set;
        i_corner_slot <= slot;
        i_coord_x <= x;
        i_coord_y <= y;
        i_coord_z <= z;
        do @(posedge i_clk); while (full);
        if (op == OP_LOAD) begin
            corners[set*4+slot][0] = x;
            corners[set*4+slot][1] = y;
            corners[set*4+slot][2] = z;
            n_loads++;
        end else begin
            sb.note_test(point_inside(set, x, y, z));
            n_tests++;
        end
    endtask

    function automatic coord_t rand_coord(int mag);
        return coord_t'($signed($urandom_range(0, 2 * mag)) - mag);
    endfunction

    // Mostly random in a modest range, sometimes full-range or extreme.
    function automatic coord_t pick_coord();
        case ($urandom_range(0, 9))
            0:       return coord_t'($urandom);
            1:       return $urandom_range(0, 1) ? coord_t'({1'b0, {(CB-1){1'b1}}})
                                                 : coord_t'({1'b1, {(CB-1){1'b0}}});
            2, 3:    return rand_coord(20);
            default: return rand_coord(2000);
        endcase
    endfunction

    task automatic load_tetra(bit set, int mag);
        for (int s = 0; s < 4; s++)
            send_request(OP_LOAD, set, 2'(s),
                         mag == 0 ? pick_coord() : rand_coord(mag),
                         mag == 0 ? pick_coord() : rand_coord(mag),
                         mag == 0 ? pick_coord() : rand_coord(mag));
    endtask

    // Query near the centroid so that inside cases occur often.
    task automatic test_near(bit set, int spread);
        longint sx, sy, sz;
        sx = 0; sy = 0; sz = 0;
        for (int s = 0; s < 4; s++) begin
            sx += corners[set*4+s][0];
            sy += corners[set*4+s][1];
            sz += corners[set*4+s][2];
        end
        send_request(OP_TEST, set, 2'($urandom_range(0, 3)),
                     coord_t'(sx / 4 + $signed($urandom_range(0, 2*spread)) - spread),
                     coord_t'(sy / 4 + $signed($urandom_range(0, 2*spread)) - spread),
                     coord_t'(sz / 4 + $signed($urandom_range(0, 2*spread)) - spread));
    endtask

    initial begin
        coord_t mx, mn;
        mx = {1'b0, {(CB-1){1'b1}}};
        mn = {1'b1, {(CB-1){1'b0}}};
        sb = new();
        for (int i = 0; i < 8; i++)
            for (int a = 0; a < 3; a++)
                corners[i][a] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: all-zero sets after reset are degenerate.
        send_request(OP_TEST, 1'b0, 2'd0, '0, '0, '0);
        send_request(OP_TEST, 1'b1, 2'd3, mx, mn, mx);
        // Corner tetrahedron with legs of 8, both orientations, and points inside, on faces, at corners, outside.
        send_request(OP_LOAD, 1'b0, 2'd0, 24'sd0, 24'sd0, 24'sd0);
        send_request(OP_LOAD, 1'b0, 2'd1, 24'sd8, 24'sd0, 24'sd0);
        send_request(OP_LOAD, 1'b0, 2'd2, 24'sd0, 24'sd8, 24'sd0);
        send_request(OP_LOAD, 1'b0, 2'd3, 24'sd0, 24'sd0, 24'sd8);
        send_request(OP_LOAD, 1'b1, 2'd0, 24'sd8, 24'sd0, 24'sd0);
        send_request(OP_LOAD, 1'b1, 2'd1, 24'sd0, 24'sd0, 24'sd0);
        send_request(OP_LOAD, 1'b1, 2'd2, 24'sd0, 24'sd8, 24'sd0);
        send_request(OP_LOAD, 1'b1, 2'd3, 24'sd0, 24'sd0, 24'sd8);
        send_request(OP_TEST, 1'b0, 2'd1, 24'sd1, 24'sd1, 24'sd1);
        send_request(OP_TEST, 1'b1, 2'd2, 24'sd1, 24'sd1, 24'sd1);
        send_request(OP_TEST, 1'b0, 2'd0, 24'sd0, 24'sd1, 24'sd1);
        send_request(OP_TEST, 1'b0, 2'd0, 24'sd8, 24'sd0, 24'sd0);
        send_request(OP_TEST, 1'b0, 2'd0, 24'sd2, 24'sd2, 24'sd4);
        send_request(OP_TEST, 1'b1, 2'd0, -24'sd1, 24'sd1, 24'sd1);
        // Extreme corners exercise the widest products.
        send_request(OP_LOAD, 1'b0, 2'd0, mn, mn, mn);
        send_request(OP_LOAD, 1'b0, 2'd1, mx, mn, mn);
        send_request(OP_LOAD, 1'b0, 2'd2, mn, mx, mn);
        send_request(OP_LOAD, 1'b0, 2'd3, mn, mn, mx);
        send_request(OP_TEST, 1'b0, 2'd0, 24'sd0 - 24'sd4000000, -24'sd4000000, -24'sd4000000);
        send_request(OP_TEST, 1'b0, 2'd3, mx, mx, mx);
        send_request(OP_TEST, 1'b0, 2'd2, mn, mn, mn);

        // Random: mostly fresh tetrahedra followed by several queries.
        while (n_loads + n_tests < 1550) begin
            if ($urandom_range(0, 4) == 0) begin
                send_request(OP_LOAD, 1'($urandom), 2'($urandom), pick_coord(),
                             pick_coord(), pick_coord());
            end else begin
                bit set;
                int mag;
                set = 1'($urandom);
                mag = $urandom_range(0, 3) == 0 ? 0 : ($urandom_range(0, 1) ? 30 : 3000000);
                load_tetra(set, mag);
                repeat ($urandom_range(2, 8)) begin
                    if ($urandom_range(0, 2) == 0)
                        send_request(OP_TEST, set, 2'($urandom), pick_coord(),
                                     pick_coord(), pick_coord());
                    else
                        test_near(set, $urandom_range(0, 1) ? 3 : (mag == 0 ? 100000 : mag));
                end
            end
        end
        push <= 1'b0;
        stim_done = 1'b1;
    end

    // Result side: pop with random stalls, sometimes back to back.
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (stall != 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            sb.check_result(o_inside_res);
        end
    end

    initial begin
        wait (stim_done);
        while (sb.inside_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("Covered %0d corner loads and %0d point tests; %0d results checked, %0d inside.",
                 n_loads, n_tests, sb.n_checked, sb.n_inside);
        if (sb.n_fail == 0 && sb.inside_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #5ms;
        $display("Timeout: results still outstanding.");
        $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire
